/* hdl/lfss_pkg.sv */
package lfss_pkg;

  // Position flags that travel with a cell from the position counter to the cell stage
  typedef struct packed {
    logic last;
    logic first_row;
    logic first_col;
  } lfss_pos_t;

endpackage

/* hdl/lfss_ram.sv */
module lfss_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lfss_pos.sv */
module lfss_pos #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_COLUMNS):0]     grid_width,
  input  logic                             advance,
  input  logic                             last_cell,
  output logic [$clog2(MAX_COLUMNS)-1:0]   col,
  output logic [$clog2(MAX_ROWS)-1:0]      row,
  output lfss_pkg::lfss_pos_t              flags
);

  localparam int SW = $clog2(MAX_COLUMNS) + 1;
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [SW-1:0] MaxWidth = SW'(MAX_COLUMNS);
  localparam logic [RW-1:0] LastRow  = RW'(MAX_ROWS - 1);

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [SW-1:0] eff_width;
  logic [SW-1:0] col_wide;
  logic [SW-1:0] col_inc;
  logic          end_of_row;

  always_comb begin
    eff_width = grid_width;
    if (grid_width == '0) begin
      eff_width = SW'(1);
    end else if (grid_width > MaxWidth) begin
      eff_width = MaxWidth;
    end
    // a width shrunk mid-row pins the column to the new last column
    if ({1'b0, column_count} >= eff_width) begin
      col_wide = eff_width - SW'(1);
    end else begin
      col_wide = {1'b0, column_count};
    end
    col_inc    = col_wide + SW'(1);
    end_of_row = col_inc >= eff_width;
  end

  always_comb begin
    column_count_next = col_inc[CW-1:0];
    row_count_next    = row_count;
    if (last_cell) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (end_of_row) begin
      column_count_next = '0;
      row_count_next    = (row_count == LastRow) ? '0 : row_count + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign col             = col_wide[CW-1:0];
  assign row             = row_count;
  assign flags.last      = last_cell;
  assign flags.first_row = (row_count == '0);
  assign flags.first_col = (col_wide == '0);

endmodule

/* hdl/lfss_cell.sv */
module lfss_cell #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             cell_free,
  input  lfss_pkg::lfss_pos_t              pos,
  input  logic [$clog2(MAX_COLUMNS)-1:0]   col,
  input  logic [$clog2(MAX_ROWS)-1:0]      row,
  input  logic [$clog2(MAX_COLUMNS):0]     up_side,
  output logic [$clog2(MAX_COLUMNS):0]     side,
  output logic [$clog2(MAX_COLUMNS):0]     best_side,
  output logic [$clog2(MAX_ROWS)-1:0]      best_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]   best_column
);

  localparam int SW = $clog2(MAX_COLUMNS) + 1;
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [SW-1:0] left_side, upper_left_side;
  logic [SW-1:0] best_size_reg;
  logic [RW-1:0] best_row_reg;
  logic [CW-1:0] best_column_reg;
  logic [SW-1:0] up, upper_left, left, min_lu, min_all;

  always_comb begin
    up         = pos.first_row ? '0 : up_side;
    upper_left = (pos.first_row || pos.first_col) ? '0 : upper_left_side;
    left       = pos.first_col ? '0 : left_side;
    min_lu     = (left < up) ? left : up;
    min_all    = (min_lu < upper_left) ? min_lu : upper_left;
    // side saturates at the field maximum
    if (!cell_free) begin
      side = '0;
    end else if (min_all == '1) begin
      side = min_all;
    end else begin
      side = min_all + SW'(1);
    end
  end

  // strict compare keeps the earliest cell on ties
  always_comb begin
    best_side   = best_size_reg;
    best_row    = best_row_reg;
    best_column = best_column_reg;
    if (side > best_size_reg) begin
      best_side   = side;
      best_row    = row;
      best_column = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_side       <= '0;
      upper_left_side <= '0;
      best_size_reg   <= '0;
      best_row_reg    <= '0;
      best_column_reg <= '0;
    end else if (advance) begin
      left_side       <= side;
      upper_left_side <= up;
      if (pos.last) begin
        best_size_reg   <= '0;
        best_row_reg    <= '0;
        best_column_reg <= '0;
      end else begin
        best_size_reg   <= best_side;
        best_row_reg    <= best_row;
        best_column_reg <= best_column;
      end
    end
  end

endmodule

/* hdl/largest_free_square_scan.sv */
// Pipeline: an accepted cell is registered in s1, then its result in the output registers.
// Throughput: one cell per cycle unless stalled; the line store has one write and one
//   registered read per cycle, with a forward path for a read of the entry just written.
// Reset: position, valid, neighbor and best registers clear, grid_width returns to
//   MAX_COLUMNS; the line store is not cleared (row 0 ignores what it reads).
module largest_free_square_scan #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             grid_width_write,
  input  logic [$clog2(MAX_COLUMNS):0]     grid_width,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cell_free,
  input  logic                             last_cell,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [$clog2(MAX_COLUMNS):0]     square_side,
  output logic [$clog2(MAX_COLUMNS):0]     best_side,
  output logic [$clog2(MAX_ROWS)-1:0]      best_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]   best_column,
  output logic                             grid_done
);

  localparam int SW = $clog2(MAX_COLUMNS) + 1;
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [SW-1:0] width_reg;
  logic          in_accept;
  logic          s1_adv;

  logic [CW-1:0]       pos_col;
  logic [RW-1:0]       pos_row;
  lfss_pkg::lfss_pos_t pos_flags;

  logic                s1_valid;
  logic                s1_free;
  logic [CW-1:0]       s1_col;
  logic [RW-1:0]       s1_row;
  lfss_pkg::lfss_pos_t s1_pos;
  logic                s1_bypass;
  logic [SW-1:0]       s1_bypass_side;

  logic [SW-1:0] ram_rdata;
  logic [SW-1:0] up_side;
  logic [SW-1:0] cell_side;
  logic [SW-1:0] cell_best_side;
  logic [RW-1:0] cell_best_row;
  logic [CW-1:0] cell_best_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= SW'(MAX_COLUMNS);
    end else if (grid_width_write) begin
      width_reg <= grid_width;
    end
  end

  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  lfss_pos #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .grid_width(width_reg),
    .advance   (in_accept),
    .last_cell (last_cell),
    .col       (pos_col),
    .row       (pos_row),
    .flags     (pos_flags)
  );

  lfss_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_COLUMNS)
  ) u_line (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_col),
    .wdata(cell_side),
    .re   (in_accept),
    .raddr(pos_col),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // read and write of the same entry on one edge: take the value being written
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_free        <= cell_free;
      s1_col         <= pos_col;
      s1_row         <= pos_row;
      s1_pos         <= pos_flags;
      s1_bypass      <= s1_adv && (s1_col == pos_col);
      s1_bypass_side <= cell_side;
    end
  end

  assign up_side = s1_bypass ? s1_bypass_side : ram_rdata;

  lfss_cell #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cell (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .cell_free  (s1_free),
    .pos        (s1_pos),
    .col        (s1_col),
    .row        (s1_row),
    .up_side    (up_side),
    .side       (cell_side),
    .best_side  (cell_best_side),
    .best_row   (cell_best_row),
    .best_column(cell_best_column)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      square_side <= cell_side;
      best_side   <= cell_best_side;
      best_row    <= cell_best_row;
      best_column <= cell_best_column;
      grid_done   <= s1_pos.last;
    end
  end

  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_side >= square_side)
    else $error("best_side below square_side");

  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_cell |=> (pos_col == '0 && pos_row == '0))
    else $error("position not cleared after last cell");

  a_obstacle_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_free |-> cell_side == '0)
    else $error("obstacle cell with nonzero side");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

endmodule

/* test/largest_free_square_scan_check.sv */
module largest_free_square_scan_check #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           grid_width_write,
  input  logic [$clog2(MAX_COLUMNS):0]   grid_width,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           cell_free,
  input  logic                           last_cell,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [$clog2(MAX_COLUMNS):0]   square_side,
  input  logic [$clog2(MAX_COLUMNS):0]   best_side,
  input  logic [$clog2(MAX_ROWS)-1:0]    best_row,
  input  logic [$clog2(MAX_COLUMNS)-1:0] best_column,
  input  logic                           grid_done,
  output int                             square_errors,
  output int                             squares_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = $clog2(MAX_COLUMNS) + 1;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int SIDE_MAX = (1 << SW) - 1;

  typedef struct packed {
    logic [SW-1:0] side;
    logic [SW-1:0] best;
    logic [RW-1:0] row;
    logic [CW-1:0] column;
    logic          done;
  } square_t;

  square_t expected_squares[$];

  // shadow of the scan state
  int row_above [MAX_COLUMNS];
  int left_q, upper_left_q, col_q, row_q;
  int best_q, best_row_q, best_col_q;
  int width_q;

  square_t got_sq, want_sq;

  initial begin
    square_errors = 0;
    squares_in_flight = 0;
    width_q = MAX_COLUMNS;
  end

  task automatic clear_scan();
    left_q = 0;
    upper_left_q = 0;
    col_q = 0;
    row_q = 0;
    best_q = 0;
    best_row_q = 0;
    best_col_q = 0;
  endtask

  task automatic advance_scan(input logic free_i, input logic last_i, output square_t res);
    int w, c, up, ul, lf, s;
    w = (width_q < 1) ? 1 : (width_q > MAX_COLUMNS) ? MAX_COLUMNS : width_q;
    c = (col_q >= w) ? w - 1 : col_q;
    up = (row_q > 0) ? row_above[c] : 0;
    ul = (row_q > 0 && c > 0) ? upper_left_q : 0;
    lf = (c > 0) ? left_q : 0;
    if (free_i) begin
      s = lf;
      if (up < s) s = up;
      if (ul < s) s = ul;
      s = s + 1;
      if (s > SIDE_MAX) s = SIDE_MAX;
    end else begin
      s = 0;
    end
    row_above[c] = s;
    upper_left_q = up;
    left_q = s;
    // strict compare keeps the earliest cell on ties
    if (s > best_q) begin
      best_q = s;
      best_row_q = row_q;
      best_col_q = c;
    end
    res.side = s;
    res.best = best_q;
    res.row = best_row_q;
    res.column = best_col_q;
    res.done = last_i;
    if (last_i) begin
      clear_scan();
    end else if (c + 1 >= w) begin
      col_q = 0;
      left_q = 0;
      upper_left_q = 0;
      row_q = (row_q + 1 >= MAX_ROWS) ? 0 : row_q + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  task automatic note_mismatch(input string what, input square_t want, input square_t got);
    square_errors++;
    if (square_errors <= 10)
      $display("%0t: %s: expected side %0d best %0d at (%0d,%0d) done %0b, got side %0d best %0d at (%0d,%0d) done %0b",
               $realtime, what, want.side, want.best, want.row, want.column, want.done,
               got.side, got.best, got.row, got.column, got.done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      width_q = MAX_COLUMNS;
      expected_squares.delete();
    end else begin
      if (grid_width_write)
        width_q = grid_width;
      // check the output transfer before queuing this edge's input
      if (out_valid && !out_stall) begin
        got_sq.side = square_side;
        got_sq.best = best_side;
        got_sq.row = best_row;
        got_sq.column = best_column;
        got_sq.done = grid_done;
        if (expected_squares.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got_sq);
        end else begin
          want_sq = expected_squares.pop_front();
          if (got_sq.side !== want_sq.side || got_sq.best !== want_sq.best ||
              got_sq.row !== want_sq.row || got_sq.column !== want_sq.column ||
              got_sq.done !== want_sq.done)
            note_mismatch("result mismatch", want_sq, got_sq);
        end
      end
      if (in_valid && !in_stall) begin
        advance_scan(cell_free, last_cell, want_sq);
        expected_squares.push_back(want_sq);
      end
    end
    squares_in_flight = expected_squares.size();
  end

endmodule

/* test/largest_free_square_scan_test.sv */
module largest_free_square_scan_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 65536;
  localparam int SW = $clog2(MAX_COLUMNS) + 1;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_CELLS = 740;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          grid_width_write = 1'b0;
  logic [SW-1:0] grid_width = SW'(MAX_COLUMNS);
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          cell_free = 1'b0;
  logic          last_cell = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [SW-1:0] square_side;
  logic [SW-1:0] best_side;
  logic [RW-1:0] best_row;
  logic [CW-1:0] best_column;
  logic          grid_done;

  int square_errors;
  int squares_in_flight;

  int burst_left = 0;
  int eff_width = MAX_COLUMNS;
  int idle_cycles = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always #5 clk = ~clk;

  largest_free_square_scan #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .grid_width_write(grid_width_write),
    .grid_width(grid_width),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cell_free(cell_free),
    .last_cell(last_cell),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .square_side(square_side),
    .best_side(best_side),
    .best_row(best_row),
    .best_column(best_column),
    .grid_done(grid_done)
  );

  largest_free_square_scan_check #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .grid_width_write(grid_width_write),
    .grid_width(grid_width),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cell_free(cell_free),
    .last_cell(last_cell),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .square_side(square_side),
    .best_side(best_side),
    .best_row(best_row),
    .best_column(best_column),
    .grid_done(grid_done),
    .square_errors(square_errors),
    .squares_in_flight(squares_in_flight)
  );

  // receiver back-pressure, segments of varying density
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 60);
      stall_mode = stall_mode_t'($urandom_range(0, 3));
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left < 20);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_cell(input logic free_v, input logic last_v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    cell_free <= free_v;
    last_cell <= last_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // register write only once the pipe has drained
  task automatic set_width(input logic [SW-1:0] w);
    in_valid <= 1'b0;
    burst_left = 0;
    while (squares_in_flight != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    grid_width_write <= 1'b1;
    grid_width <= w;
    @(negedge clk);
    grid_width_write <= 1'b0;
    eff_width = (w == 0) ? 1 : (w > MAX_COLUMNS) ? MAX_COLUMNS : int'(w);
  endtask

  // mid-grid width change only shrinks, so no unwritten line entry is read
  task automatic send_grid(input int cells, input int free_pct, input int shrink_at);
    for (int i = 0; i < cells; i++) begin
      if (i == shrink_at)
        set_width(SW'($urandom_range(0, eff_width)));
      send_cell($urandom_range(0, 99) < free_pct, i == cells - 1);
    end
  endtask

  initial begin
    int random_cells;
    int w, cells, pct, shrink;
    random_cells = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero width behaves as a single column
    set_width('0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b1);
    // full 3x3 square
    set_width(SW'(3));
    send_grid(9, 100, -1);
    // no free cell at all
    set_width(SW'(2));
    send_grid(4, 0, -1);
    // ties in row 0, then shrink mid-row so the column clamps
    set_width(SW'(4));
    for (int i = 0; i < 6; i++) send_cell(1'b1, 1'b0);
    set_width(SW'(2));
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);

    // oversized width acts as a full row, so a short grid stays in row 0
    set_width('1);
    send_grid(40, 90, -1);

    while (random_cells < RANDOM_CELLS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = $urandom_range(13, 40);
          default: w = $urandom_range(1, 12);
        endcase
        set_width(SW'(w));
      end
      cells = eff_width * $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) cells = $urandom_range(1, cells);
      if (cells > 160) cells = 160;
      case ($urandom_range(0, 3))
        0:       pct = 50;
        1:       pct = 80;
        2:       pct = 95;
        default: pct = 100;
      endcase
      shrink = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cells - 1) : -1;
      send_grid(cells, pct, shrink);
      random_cells += cells;
    end

    in_valid <= 1'b0;
    while (squares_in_flight != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (square_errors == 0 && squares_in_flight == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
